[rtl/core/rcfr_pkg.sv]
// Shared types and constants for the RC command frame receiver.
// No dependencies; every other file in rtl/core refers to this package by scoped names.

package rcfr_pkg;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Frame format.
  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;
  localparam int unsigned DATA_BYTES = 12;
  localparam int unsigned CHANNELS   = DATA_BYTES / 2;
  localparam int unsigned DCNT_W     = $clog2(DATA_BYTES);

  // Link timing.
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [15:0] AGE_MAX       = 16'hFFFF;

  // Frame parser states.
  typedef enum logic [1:0] {
    ST_HUNT,
    ST_HEADER,
    ST_DATA,
    ST_CHECK
  } parse_state_t;

  // Frame completion status from the parser.
  typedef struct packed {
    logic good;
    logic bad;
  } frame_evt_t;

  typedef logic [15:0] chan_t;

endpackage

[rtl/core/rcfr_parser.sv]
// Header hunt, data gathering, XOR check and channel latch of the frame receiver.
// Depends on rcfr_pkg.

module rcfr_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_fire,
  input  logic [7:0]          rx_byte,
  output rcfr_pkg::frame_evt_t evt,
  output rcfr_pkg::chan_t     chan_r [rcfr_pkg::CHANNELS]
);

  rcfr_pkg::parse_state_t state_r, state_nxt;
  logic [rcfr_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] pend_r [rcfr_pkg::DATA_BYTES];
  logic shift_en;

  always_comb begin
    state_nxt = state_r;
    dcnt_nxt  = dcnt_r;
    xor_nxt   = xor_r;
    shift_en  = 1'b0;
    evt       = '0;
    if (byte_fire) begin
      case (state_r)
        rcfr_pkg::ST_HUNT: begin
          if (rx_byte == rcfr_pkg::HDR_FIRST) begin
            state_nxt = rcfr_pkg::ST_HEADER;
          end
        end
        rcfr_pkg::ST_HEADER: begin
          // Anything but the second header byte, a repeated first byte included,
          // sends the parser back to hunting.
          if (rx_byte == rcfr_pkg::HDR_SECOND) begin
            state_nxt = rcfr_pkg::ST_DATA;
            dcnt_nxt  = '0;
            xor_nxt   = '0;
          end else begin
            state_nxt = rcfr_pkg::ST_HUNT;
          end
        end
        rcfr_pkg::ST_DATA: begin
          shift_en = 1'b1;
          xor_nxt  = xor_r ^ rx_byte;
          dcnt_nxt = dcnt_r + rcfr_pkg::DCNT_W'(1);
          if (dcnt_r == rcfr_pkg::DCNT_W'(rcfr_pkg::DATA_BYTES - 1)) begin
            state_nxt = rcfr_pkg::ST_CHECK;
          end
        end
        rcfr_pkg::ST_CHECK: begin
          evt.good  = (xor_r == rx_byte);
          evt.bad   = (xor_r != rx_byte);
          xor_nxt   = '0;
          state_nxt = rcfr_pkg::ST_HUNT;
        end
        default: begin
          state_nxt = rcfr_pkg::ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcfr_pkg::ST_HUNT;
      dcnt_r  <= '0;
      xor_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dcnt_r  <= dcnt_nxt;
      xor_r   <= xor_nxt;
    end
  end

  // Data bytes shift in at the top, so after a full frame entry 0 holds the first byte.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < rcfr_pkg::DATA_BYTES - 1; i++) begin
        pend_r[i] <= pend_r[i+1];
      end
      pend_r[rcfr_pkg::DATA_BYTES-1] <= rx_byte;
    end
  end

  // Channels are little-endian byte pairs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < rcfr_pkg::CHANNELS; k++) begin
        chan_r[k] <= '0;
      end
    end else if (evt.good) begin
      for (int k = 0; k < rcfr_pkg::CHANNELS; k++) begin
        chan_r[k] <= {pend_r[2*k+1], pend_r[2*k]};
      end
    end
  end

  a_evt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.good && evt.bad))
    else $error("frame reported both good and bad");

  a_evt_at_check: assert property (@(posedge clk) disable iff (!rst_n)
    (evt.good || evt.bad) |->
      (state_r == rcfr_pkg::ST_CHECK &&
       dcnt_r == rcfr_pkg::DCNT_W'(rcfr_pkg::DATA_BYTES)))
    else $error("frame completed outside the check byte");

endmodule

[rtl/core/rcfr_link_timer.sv]
// Link age counter, timeout register and active flag of the frame receiver.
// Depends on rcfr_pkg.

module rcfr_link_timer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 tick_fire,
  input  rcfr_pkg::frame_evt_t evt,
  output logic                 active_r
);

  logic [15:0] timeout_r;
  logic [15:0] age_r, age_nxt, age_inc;
  logic        seen_r, seen_nxt;
  logic        active_nxt;

  assign age_inc = (age_r == rcfr_pkg::AGE_MAX) ? age_r : age_r + 16'd1;

  always_comb begin
    age_nxt    = age_r;
    seen_nxt   = seen_r;
    active_nxt = active_r;
    if (evt.good) begin
      age_nxt    = '0;
      seen_nxt   = 1'b1;
      active_nxt = 1'b1;
    end else if (tick_fire) begin
      age_nxt = age_inc;
      // The timeout is tested against the freshly incremented age.
      if (seen_r && (age_inc > timeout_r)) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= rcfr_pkg::TIMEOUT_RESET;
      age_r     <= '0;
      seen_r    <= 1'b0;
      active_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      age_r    <= age_nxt;
      seen_r   <= seen_nxt;
      active_r <= active_nxt;
    end
  end

  a_good_refresh: assert property (@(posedge clk) disable iff (!rst_n)
    evt.good |=> (active_r && seen_r && age_r == '0))
    else $error("good frame did not refresh the link");

  a_active_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> seen_r)
    else $error("link active before any frame");

endmodule

[rtl/core/rc_command_frame_receiver_unit.sv]
// Top level of the RC command frame receiver: input register, parser, link timer
// and result register. Depends on rcfr_pkg, rcfr_parser and rcfr_link_timer.

// One input beat (a received byte or a millisecond tick) is taken every clock cycle
// when the result side keeps up; each beat waits in the input register, and its
// result beat is valid when it loads the result register together with the frame
// state. in_ready follows out_ready combinationally when both registers are full.
// Frames are 0xAA, 0x55, twelve data bytes and an XOR check byte; the six channels
// and link_active on the result port are the values after that beat was processed.
// timeout_ms is written through cfg_wr_en/cfg_wr_data, resets to 500 and is only
// compared on ticks.
module rc_command_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_new_frame,
  output logic        out_checksum_error,
  output logic [15:0] out_roll,
  output logic [15:0] out_pitch,
  output logic [15:0] out_throttle,
  output logic [15:0] out_yaw,
  output logic [15:0] out_aux_one,
  output logic [15:0] out_aux_two,
  output logic        out_link_active
);

  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;
  logic       s1_advance, s1_fire, in_fire;
  logic       out_valid_r;
  rcfr_pkg::frame_evt_t evt, evt_r;
  rcfr_pkg::chan_t      chan_r [rcfr_pkg::CHANNELS];
  logic       active_r;

  // The frame state and the result register load together, so the latched
  // channels and the link flag can be shown straight from the state.
  assign s1_advance = !out_valid_r || out_ready;
  assign s1_fire    = s1_valid_r && s1_advance;
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_fire    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      evt_r       <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
        evt_r       <= evt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_operation;
      s1_byte_r <= in_rx_byte;
    end
  end

  rcfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (s1_fire && (s1_op_r == rcfr_pkg::OP_BYTE)),
    .rx_byte   (s1_byte_r),
    .evt       (evt),
    .chan_r    (chan_r)
  );

  rcfr_link_timer u_link_timer (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick_fire   (s1_fire && (s1_op_r == rcfr_pkg::OP_TICK)),
    .evt         (evt),
    .active_r    (active_r)
  );

  assign out_valid          = out_valid_r;
  assign out_new_frame      = evt_r.good;
  assign out_checksum_error = evt_r.bad;
  assign out_roll           = chan_r[0];
  assign out_pitch          = chan_r[1];
  assign out_throttle       = chan_r[2];
  assign out_yaw            = chan_r[3];
  assign out_aux_one        = chan_r[4];
  assign out_aux_two        = chan_r[5];
  assign out_link_active    = active_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_advance) |=> s1_valid_r)
    else $error("input beat lost while result stalled");

  a_flags_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_r.good || evt_r.bad) |-> out_valid_r)
    else $error("frame status without a result beat");

endmodule

[sim/tb_rc_command_frame_receiver_unit.sv]
// Self-checking testbench for rc_command_frame_receiver_unit: a queue-fed beat driver,
// a result monitor and an in-bench predictor of the frame parser and link-age timer.
// Depends on rcfr_pkg and on the RTL under rtl/core.

module tb_rc_command_frame_receiver_unit;
  import rcfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  // Frame position as tracked by the predictor.
  localparam logic [3:0] POS_HUNT   = 4'd0;
  localparam logic [3:0] POS_HEADER = 4'd1;
  localparam logic [3:0] POS_DATA0  = 4'd2;
  localparam logic [3:0] POS_CHECK  = 4'd14;

  // Extreme data bytes for the directed frame, byte 0 last.
  localparam logic [DATA_BYTES-1:0][7:0] EXTREME_DATA = {
    8'h00, 8'hFF, 8'h34, 8'h12, 8'hAA, 8'h55, 8'h7F, 8'hFE, 8'h80, 8'h01, 8'hFF, 8'h00
  };

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_beat_t;

  typedef struct packed {
    logic                        new_frame;
    logic                        checksum_error;
    logic [CHANNELS-1:0][15:0]   chans;
    logic                        link_active;
  } link_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_new_frame;
  logic        out_checksum_error;
  logic [15:0] out_roll;
  logic [15:0] out_pitch;
  logic [15:0] out_throttle;
  logic [15:0] out_yaw;
  logic [15:0] out_aux_one;
  logic [15:0] out_aux_two;
  logic        out_link_active;

  // Predictor state.
  logic [15:0]                 model_timeout;
  logic [3:0]                  model_pos;
  logic [DATA_BYTES-1:0][7:0]  model_pending;
  logic [7:0]                  model_xor;
  logic [CHANNELS-1:0][15:0]   model_chans;
  logic [15:0]                 model_age;
  logic                        model_seen;
  logic                        model_active;

  rx_beat_t     beats_to_send[$];
  link_result_t awaited_results[$];
  int unsigned  beats_queued;
  int unsigned  beats_accepted;
  int unsigned  mismatch_count;
  int unsigned  cycle_count;
  int unsigned  sender_idle_pct;
  int unsigned  receiver_idle_pct;
  logic         in_taken;
  rx_beat_t     next_beat;
  link_result_t want;
  logic [CHANNELS-1:0][15:0] got_chans;
  string        chan_names[CHANNELS] = '{"roll", "pitch", "throttle", "yaw", "aux_one", "aux_two"};

  rc_command_frame_receiver_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_new_frame      (out_new_frame),
    .out_checksum_error (out_checksum_error),
    .out_roll           (out_roll),
    .out_pitch          (out_pitch),
    .out_throttle       (out_throttle),
    .out_yaw            (out_yaw),
    .out_aux_one        (out_aux_one),
    .out_aux_two        (out_aux_two),
    .out_link_active    (out_link_active)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_link_model();
    model_timeout = TIMEOUT_RESET;
    model_pos     = POS_HUNT;
    model_pending = '0;
    model_xor     = 8'h00;
    model_chans   = '0;
    model_age     = 16'h0000;
    model_seen    = 1'b0;
    model_active  = 1'b0;
  endfunction

  // Advances the parser and link timer by one beat and returns the result it produces.
  function automatic link_result_t step_link_model(logic op, logic [7:0] b);
    link_result_t r;
    r.new_frame      = 1'b0;
    r.checksum_error = 1'b0;
    if (op == OP_BYTE) begin
      if (model_pos == POS_HEADER) begin
        if (b == HDR_SECOND) begin
          model_xor = 8'h00;
          model_pos = POS_DATA0;
        end else begin
          model_pos = POS_HUNT;
        end
      end else if (model_pos >= POS_DATA0 && model_pos < POS_CHECK) begin
        model_pending[model_pos - POS_DATA0] = b;
        model_xor = model_xor ^ b;
        model_pos = model_pos + 4'd1;
      end else if (model_pos == POS_CHECK) begin
        if (model_xor == b) begin
          for (int k = 0; k < CHANNELS; k++)
            model_chans[k] = {model_pending[2*k+1], model_pending[2*k]};
          model_active = 1'b1;
          model_seen   = 1'b1;
          model_age    = 16'h0000;
          r.new_frame  = 1'b1;
        end else begin
          r.checksum_error = 1'b1;
        end
        model_xor = 8'h00;
        model_pos = POS_HUNT;
      end else begin
        model_pos = (b == HDR_FIRST) ? POS_HEADER : POS_HUNT;
      end
    end else begin
      if (model_age != AGE_MAX) model_age = model_age + 16'd1;
      if (model_seen && model_age > model_timeout) model_active = 1'b0;
    end
    r.chans       = model_chans;
    r.link_active = model_active;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic queue_beat(logic op, logic [7:0] data);
    rx_beat_t beat;
    beat.op   = op;
    beat.data = data;
    beats_to_send.push_back(beat);
    beats_queued++;
  endtask

  // A full frame; check_flip of zero gives a good check byte. Ticks may be
  // slipped in between bytes, which must not disturb the parser.
  task automatic queue_frame(logic [DATA_BYTES-1:0][7:0] data, logic [7:0] check_flip,
                             int unsigned tick_pct);
    logic [7:0] sum;
    sum = 8'h00;
    queue_beat(OP_BYTE, HDR_FIRST);
    queue_beat(OP_BYTE, HDR_SECOND);
    for (int i = 0; i < DATA_BYTES; i++) begin
      if ($urandom_range(99) < tick_pct) queue_beat(OP_TICK, 8'($urandom));
      queue_beat(OP_BYTE, data[i]);
      sum = sum ^ data[i];
    end
    if ($urandom_range(99) < tick_pct) queue_beat(OP_TICK, 8'($urandom));
    queue_beat(OP_BYTE, sum ^ check_flip);
  endtask

  task automatic queue_random_traffic(int unsigned count);
    int unsigned goal;
    int unsigned pick;
    logic [DATA_BYTES-1:0][7:0] data;
    logic [7:0] b;
    goal = beats_queued + count;
    while (beats_queued < goal) begin
      pick = $urandom_range(99);
      for (int i = 0; i < DATA_BYTES; i++) data[i] = 8'($urandom);
      if (pick < 55) begin
        queue_frame(data, 8'h00, 8);
      end else if (pick < 67) begin
        queue_frame(data, 8'($urandom_range(1, 255)), 8);
      end else if (pick < 75) begin
        // Broken header: the second byte is anything but 0x55.
        b = 8'($urandom);
        if (b == HDR_SECOND) b = HDR_FIRST;
        queue_beat(OP_BYTE, HDR_FIRST);
        queue_beat(OP_BYTE, b);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 12)) queue_beat(OP_TICK, 8'($urandom));
      end else begin
        queue_beat(OP_BYTE, 8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (beats_accepted != beats_queued || awaited_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_drained();
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Beat driver: a new beat is offered only once the previous one has been taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_beat = beats_to_send.pop_front();
        in_valid     <= 1'b1;
        in_operation <= next_beat.op;
        in_rx_byte   <= next_beat.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Monitor: predicts on each accepted input beat and checks each result beat.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) model_timeout = cfg_wr_data;
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        beats_accepted++;
        awaited_results.push_back(step_link_model(in_operation, in_rx_byte));
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          note_mismatch("result beat with nothing expected");
        end else begin
          want = awaited_results.pop_front();
          got_chans = {out_aux_two, out_aux_one, out_yaw, out_throttle, out_pitch, out_roll};
          if (out_new_frame !== want.new_frame)
            note_mismatch($sformatf("new_frame %b, expected %b", out_new_frame,
                                    want.new_frame));
          if (out_checksum_error !== want.checksum_error)
            note_mismatch($sformatf("checksum_error %b, expected %b", out_checksum_error,
                                    want.checksum_error));
          for (int k = 0; k < CHANNELS; k++)
            if (got_chans[k] !== want.chans[k])
              note_mismatch($sformatf("%s %h, expected %h", chan_names[k], got_chans[k],
                                      want.chans[k]));
          if (out_link_active !== want.link_active)
            note_mismatch($sformatf("link_active %b, expected %b", out_link_active,
                                    want.link_active));
        end
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 16'h0000;
    in_valid          = 1'b0;
    in_operation      = OP_BYTE;
    in_rx_byte        = 8'h00;
    out_ready         = 1'b0;
    in_taken          = 1'b0;
    beats_queued      = 0;
    beats_accepted    = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    sender_idle_pct   = 34;
    receiver_idle_pct = 78;
    reset_link_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats with the reset timeout: a tick before any frame, a good frame
    // of extreme bytes, a repeated 0xAA in place of 0x55 and a broken header.
    queue_beat(OP_TICK, 8'hFF);
    queue_frame(EXTREME_DATA, 8'h00, 0);
    queue_beat(OP_BYTE, HDR_FIRST);
    queue_beat(OP_BYTE, HDR_FIRST);
    queue_beat(OP_BYTE, HDR_SECOND);
    queue_beat(OP_BYTE, HDR_FIRST);
    queue_beat(OP_BYTE, 8'h12);
    queue_beat(OP_TICK, 8'h00);

    write_timeout(16'h0000);
    queue_random_traffic(220);

    write_timeout(16'($urandom_range(1, 20)));
    sender_idle_pct   = 78;
    receiver_idle_pct = 34;
    queue_random_traffic(220);

    write_timeout(AGE_MAX);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    queue_random_traffic(210);

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/rcfr_pkg.sv
rtl/core/rcfr_parser.sv
rtl/core/rcfr_link_timer.sv
rtl/core/rc_command_frame_receiver_unit.sv
sim/tb_rc_command_frame_receiver_unit.sv
